@@ rtl/gfp_pkg.sv @@
package gfp_pkg;

  localparam int unsigned REC_LEN = 35;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // what one character does to the field state
  typedef enum logic [3:0] {
    TK_NONE,
    TK_ERR,
    TK_HOUR,
    TK_MIN,
    TK_SEC,
    TK_LAT_DEG,
    TK_LAT_MIN,
    TK_SOUTH,
    TK_LON_DEG,
    TK_LON_MIN,
    TK_WEST,
    TK_PALT,
    TK_GALT,
    TK_PNEG,
    TK_GNEG
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       last;
    logic       full;   // line reached all record positions
  } token_t;

  function automatic logic [16:0] dec_step(logic [16:0] acc, logic [3:0] d);
    return 17'(acc * 17'd10) + 17'(d);
  endfunction

endpackage

@@ rtl/gfp_in_if.sv @@
interface gfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       line_end;

  modport source (output valid, output character, output line_end, input ready);
  modport sink (input valid, input character, input line_end, output ready);
endinterface

@@ rtl/gfp_out_if.sv @@
interface gfp_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic        [18:0] time_seconds;
  logic signed [23:0] latitude;
  logic signed [26:0] longitude;
  logic signed [17:0] baro_altitude;
  logic signed [17:0] gnss_altitude;

  modport source (
    output valid, output valid_res, output time_seconds, output latitude,
    output longitude, output baro_altitude, output gnss_altitude, input ready
  );
  modport sink (
    input valid, input valid_res, input time_seconds, input latitude,
    input longitude, input baro_altitude, input gnss_altitude, output ready
  );
endinterface

@@ rtl/gfp_front.sv @@
module gfp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_character,
  input  logic            in_line_end,
  output logic            tok_valid,
  input  logic            tok_ready,
  output gfp_pkg::token_t tok
);
  import gfp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             is_digit;
  logic             accept;
  tok_kind_t        kind;

  assign is_digit = (in_character >= CH_ZERO) && (in_character <= CH_NINE);
  assign in_ready  = tok_ready;
  assign tok_valid = in_valid;
  assign accept    = in_valid && tok_ready;

  always_comb begin
    kind = TK_NONE;
    priority if (pos_r == POS_W'(0)) begin
      kind = (in_character == CH_B) ? TK_NONE : TK_ERR;
    end else if (pos_r <= POS_W'(2)) begin
      kind = is_digit ? TK_HOUR : TK_ERR;
    end else if (pos_r <= POS_W'(4)) begin
      kind = is_digit ? TK_MIN : TK_ERR;
    end else if (pos_r <= POS_W'(6)) begin
      kind = is_digit ? TK_SEC : TK_ERR;
    end else if (pos_r <= POS_W'(8)) begin
      kind = is_digit ? TK_LAT_DEG : TK_ERR;
    end else if (pos_r <= POS_W'(13)) begin
      kind = is_digit ? TK_LAT_MIN : TK_ERR;
    end else if (pos_r == POS_W'(14)) begin
      kind = (in_character == CH_S) ? TK_SOUTH : TK_NONE;
    end else if (pos_r <= POS_W'(17)) begin
      kind = is_digit ? TK_LON_DEG : TK_ERR;
    end else if (pos_r <= POS_W'(22)) begin
      kind = is_digit ? TK_LON_MIN : TK_ERR;
    end else if (pos_r == POS_W'(23)) begin
      kind = (in_character == CH_W) ? TK_WEST : TK_NONE;
    end else if (pos_r == POS_W'(24)) begin
      kind = (in_character == CH_A) ? TK_NONE : TK_ERR;
    end else if (pos_r <= POS_W'(29)) begin
      if (pos_r == POS_W'(25) && in_character == CH_MINUS) begin
        kind = TK_PNEG;
      end else begin
        kind = is_digit ? TK_PALT : TK_ERR;
      end
    end else if (pos_r < POS_W'(REC_LEN)) begin
      if (pos_r == POS_W'(30) && in_character == CH_MINUS) begin
        kind = TK_GNEG;
      end else begin
        kind = is_digit ? TK_GALT : TK_ERR;
      end
    end else begin
      kind = TK_NONE;   // past the record: ignored
    end
  end

  always_comb begin
    tok.kind  = kind;
    tok.digit = 4'(in_character - CH_ZERO);
    tok.last  = in_line_end;
    tok.full  = (pos_r >= POS_W'(REC_LEN - 1));
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_line_end) begin
        pos_nxt = '0;
      end else if (pos_r < POS_W'(REC_LEN)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ rtl/gfp_fifo.sv @@
module gfp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  gfp_pkg::token_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output gfp_pkg::token_t pop_data
);
  import gfp_pkg::*;

  token_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/gfp_back.sv @@
module gfp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tok_valid,
  output logic                      tok_ready,
  input  gfp_pkg::token_t           tok,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_valid_res,
  output logic               [18:0] out_time_seconds,
  output logic signed        [23:0] out_latitude,
  output logic signed        [26:0] out_longitude,
  output logic signed        [17:0] out_baro_altitude,
  output logic signed        [17:0] out_gnss_altitude
);
  import gfp_pkg::*;

  typedef struct packed {
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  lat_deg;
    logic [16:0] lat_min;
    logic [9:0]  lon_deg;
    logic [16:0] lon_min;
    logic        south;
    logic        west;
    logic [16:0] palt;
    logic [16:0] galt;
    logic        pneg;
    logic        gneg;
    logic        err;
  } acc_t;

  acc_t acc_r, acc_nxt, applied;
  acc_t fin_r, fin_nxt;
  logic fin_valid_r, fin_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic pop, fin_free, out_load;

  logic               res_valid;
  logic        [18:0] res_time;
  logic        [22:0] lat_mag;
  logic        [25:0] lon_mag;
  logic        [16:0] g_mag;
  logic               g_neg;
  logic signed [23:0] res_lat;
  logic signed [26:0] res_lon;
  logic signed [17:0] res_palt;
  logic signed [17:0] res_galt;

  logic               valid_res_r;
  logic        [18:0] time_r;
  logic signed [23:0] lat_r;
  logic signed [26:0] lon_r;
  logic signed [17:0] palt_r;
  logic signed [17:0] galt_r;

  // handshake between the stages
  assign out_load  = fin_valid_r && (!out_valid_r || out_ready);
  assign fin_free  = !fin_valid_r || out_load;
  assign tok_ready = !tok.last || fin_free;
  assign pop       = tok_valid && tok_ready;

  // field update for one character
  always_comb begin
    applied = acc_r;
    unique case (tok.kind)
      TK_NONE:    applied = acc_r;
      TK_ERR:     applied.err = 1'b1;
      TK_HOUR:    applied.hour = 7'(dec_step(17'(acc_r.hour), tok.digit));
      TK_MIN:     applied.minute = 7'(dec_step(17'(acc_r.minute), tok.digit));
      TK_SEC:     applied.second = 7'(dec_step(17'(acc_r.second), tok.digit));
      TK_LAT_DEG: applied.lat_deg = 7'(dec_step(17'(acc_r.lat_deg), tok.digit));
      TK_LAT_MIN: applied.lat_min = dec_step(acc_r.lat_min, tok.digit);
      TK_SOUTH:   applied.south = 1'b1;
      TK_LON_DEG: applied.lon_deg = 10'(dec_step(17'(acc_r.lon_deg), tok.digit));
      TK_LON_MIN: applied.lon_min = dec_step(acc_r.lon_min, tok.digit);
      TK_WEST:    applied.west = 1'b1;
      TK_PALT:    applied.palt = dec_step(acc_r.palt, tok.digit);
      TK_GALT:    applied.galt = dec_step(acc_r.galt, tok.digit);
      TK_PNEG:    applied.pneg = 1'b1;
      TK_GNEG:    applied.gneg = 1'b1;
      default:    applied = acc_r;
    endcase
    if (tok.last && !tok.full) begin
      applied.err = 1'b1;   // short line
    end
  end

  always_comb begin
    acc_nxt       = acc_r;
    fin_nxt       = fin_r;
    fin_valid_nxt = fin_valid_r && !out_load;
    if (pop) begin
      if (tok.last) begin
        acc_nxt       = '0;
        fin_nxt       = applied;
        fin_valid_nxt = 1'b1;
      end else begin
        acc_nxt = applied;
      end
    end
  end

  // result arithmetic on the finished line
  always_comb begin
    res_valid = !fin_r.err;
    res_time  = 19'(fin_r.hour) * 19'd3600 + 19'(fin_r.minute) * 19'd60
              + 19'(fin_r.second);
    lat_mag   = 23'(fin_r.lat_deg) * 23'd60000 + 23'(fin_r.lat_min);
    lon_mag   = 26'(fin_r.lon_deg) * 26'd60000 + 26'(fin_r.lon_min);
    g_mag     = fin_r.galt;
    g_neg     = fin_r.gneg;
    if (fin_r.palt != '0 && fin_r.galt == '0) begin
      g_mag = fin_r.palt;
      g_neg = fin_r.pneg;
    end
    res_lat  = fin_r.south ? -$signed({1'b0, lat_mag}) : $signed({1'b0, lat_mag});
    res_lon  = fin_r.west ? -$signed({1'b0, lon_mag}) : $signed({1'b0, lon_mag});
    res_palt = fin_r.pneg ? -$signed({1'b0, fin_r.palt}) : $signed({1'b0, fin_r.palt});
    res_galt = g_neg ? -$signed({1'b0, g_mag}) : $signed({1'b0, g_mag});
    if (!res_valid) begin
      res_time = '0;
      res_lat  = '0;
      res_lon  = '0;
      res_palt = '0;
      res_galt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
    if (out_load) begin
      valid_res_r <= res_valid;
      time_r      <= res_time;
      lat_r       <= res_lat;
      lon_r       <= res_lon;
      palt_r      <= res_palt;
      galt_r      <= res_galt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_valid_res     = valid_res_r;
  assign out_time_seconds  = time_r;
  assign out_latitude      = lat_r;
  assign out_longitude     = lon_r;
  assign out_baro_altitude = palt_r;
  assign out_gnss_altitude = galt_r;

endmodule

@@ rtl/gps_fix_record_parser.sv @@
// channel   dir  beat                          payload
// in_chan   in   one record character          character[7:0], line_end
// out_chan  out  one parsed fix per line_end   valid_res, time_seconds[18:0],
//                                              latitude[23:0], longitude[26:0],
//                                              baro_altitude[17:0],
//                                              gnss_altitude[17:0]
//
// one character beat per cycle while the token queue is not full; set by the classify
// and digit accumulate steps
// out_chan valid rises once the line_end beat has passed the token queue and the line
// snapshot and has then been loaded into the output register
// reset (rst_n low, synchronous) clears the position, the field state and all queues
// either side may stall: the token queue and the output register absorb it
module gps_fix_record_parser (
  input logic       clk,
  input logic       rst_n,
  gfp_in_if.sink    in_chan,
  gfp_out_if.source out_chan
);
  import gfp_pkg::*;

  // classified character tokens, front to queue
  logic   fq_valid;
  logic   fq_ready;
  token_t fq_tok;

  // queue to back end
  logic   qb_valid;
  logic   qb_ready;
  token_t qb_tok;

  // front end: position counter and per-character field decode
  gfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_character (in_chan.character),
    .in_line_end  (in_chan.line_end),
    .tok_valid    (fq_valid),
    .tok_ready    (fq_ready),
    .tok          (fq_tok)
  );

  // short token queue so the front keeps taking beats while the back end waits
  gfp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_tok),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_tok)
  );

  // back end: field accumulators, line snapshot, result arithmetic, output register
  gfp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok_valid         (qb_valid),
    .tok_ready         (qb_ready),
    .tok               (qb_tok),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_valid_res     (out_chan.valid_res),
    .out_time_seconds  (out_chan.time_seconds),
    .out_latitude      (out_chan.latitude),
    .out_longitude     (out_chan.longitude),
    .out_baro_altitude (out_chan.baro_altitude),
    .out_gnss_altitude (out_chan.gnss_altitude)
  );

endmodule
